// File: design/cpt_pkg.sv
// shared widths and payload types for the closest point on triangle block
`timescale 1ns / 1ps

package cpt_pkg;

  localparam int COORD_W = 32;
  // edge and offset vectors
  localparam int DIFF_W  = COORD_W + 1;
  // dot products of two difference vectors
  localparam int DOT_W   = 2 * DIFF_W + 2;
  // barycentric cross terms such as d1*d4 - d3*d2
  localparam int VOL_W   = 2 * DOT_W + 1;
  localparam int DEN_W   = VOL_W + 2;
  localparam int NUM_W   = DIFF_W + VOL_W + 1;
  // quotient magnitude bits, two guard bits above the coordinate range
  localparam int QUO_W   = COORD_W + 2;
  // operand slice width of the pipelined multipliers
  localparam int CHUNK_W = 32;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    coord_t vert_a_x;
    coord_t vert_a_y;
    coord_t vert_a_z;
    coord_t vert_b_x;
    coord_t vert_b_y;
    coord_t vert_b_z;
    coord_t vert_c_x;
    coord_t vert_c_y;
    coord_t vert_c_z;
  } cpt_in_t;

  typedef struct packed {
    coord_t near_x;
    coord_t near_y;
    coord_t near_z;
  } cpt_out_t;

endpackage

// File: design/cpt_mul.sv
// pipelined signed multiplier, one slice product per register stage
`timescale 1ns / 1ps

module cpt_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int CW = cpt_pkg::CHUNK_W;
  localparam int NA = (AW + CW - 1) / CW;
  localparam int NB = (BW + CW - 1) / CW;
  localparam int NS = NA * NB;
  localparam int PW = AW + BW;
  localparam int XA = NA * CW;
  localparam int XB = NB * CW;

  logic [XA-1:0]        a_q   [NS];
  logic [XB-1:0]        b_q   [NS];
  logic signed [PW-1:0] acc_q [NS];
  logic [XA-1:0]        a_x;
  logic [XB-1:0]        b_x;

  // sign extended so the top slice can be taken as a signed digit
  assign a_x = XA'(a_i);
  assign b_x = XB'(b_i);

  for (genvar s = 0; s < NS; s++) begin : g_stg
    localparam int IA = s / NB;
    localparam int IB = s % NB;
    localparam int SH = (IA + IB) * CW;

    logic [XA-1:0]          a_in;
    logic [XB-1:0]          b_in;
    logic signed [PW-1:0]   acc_in;
    logic signed [CW:0]     da;
    logic signed [CW:0]     db;
    logic signed [2*CW+1:0] pp;
    logic signed [PW-1:0]   term;

    if (s == 0) begin : g_first
      assign a_in   = a_x;
      assign b_in   = b_x;
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_q[s-1];
      assign b_in   = b_q[s-1];
      assign acc_in = acc_q[s-1];
    end

    // lower slices are unsigned digits, the top slice carries the sign
    if (IA == NA - 1) begin : g_atop
      assign da = {a_in[IA*CW+CW-1], a_in[IA*CW +: CW]};
    end else begin : g_alow
      assign da = {1'b0, a_in[IA*CW +: CW]};
    end
    if (IB == NB - 1) begin : g_btop
      assign db = {b_in[IB*CW+CW-1], b_in[IB*CW +: CW]};
    end else begin : g_blow
      assign db = {1'b0, b_in[IB*CW +: CW]};
    end

    assign pp   = da * db;
    assign term = PW'(pp) <<< SH;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[s]   <= a_in;
        b_q[s]   <= b_in;
        acc_q[s] <= acc_in + term;
      end
    end
  end

  assign p_o = acc_q[NS-1];

endmodule

// File: design/closest_point_on_triangle.sv
// Closest point on a triangle: takes a query point and three vertices (signed Q16.16) and
// returns the nearest point of the triangle, saturated to Q16.16. One transaction is
// accepted every clock cycle while the output is not stalled. The pipeline contains the
// 34 one-bit stages of the rounding divider and the sliced multipliers (4 stages for the
// dot products, 9 for the barycentric cross terms, 10 for the numerators). The whole
// pipeline advances together: it only holds while a finished result sits at the output
// unaccepted. Degenerate triangles and edges return a vertex.
`timescale 1ns / 1ps

module closest_point_on_triangle (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cpt_pkg::cpt_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cpt_pkg::cpt_out_t  out_data_o
);

  localparam int CW      = cpt_pkg::CHUNK_W;
  localparam int COORD_W = cpt_pkg::COORD_W;
  localparam int DIFF_W  = cpt_pkg::DIFF_W;
  localparam int DOT_W   = cpt_pkg::DOT_W;
  localparam int VOL_W   = cpt_pkg::VOL_W;
  localparam int DEN_W   = cpt_pkg::DEN_W;
  localparam int NUM_W   = cpt_pkg::NUM_W;
  localparam int QW      = cpt_pkg::QUO_W;
  localparam int EDG_W   = DOT_W + 1;
  localparam int REM_W   = DEN_W + 1;
  localparam int SUM_W   = QW + 3;

  localparam int N1 = (DIFF_W + CW - 1) / CW;
  localparam int N2 = (DOT_W + CW - 1) / CW;
  localparam int NV = (VOL_W + CW - 1) / CW;
  localparam int L1 = N1 * N1;
  localparam int L2 = N2 * N2;
  localparam int L3 = N1 * NV;
  localparam int NST = 9 + L1 + L2 + L3 + QW;

  // delay line lengths for data that bypasses the multipliers
  localparam int VT_D = 3 + L1 + L2;
  localparam int ED_D = 2 + L1 + L2;
  localparam int DT_D = L2;
  localparam int BS_D = 3 + L3 + QW;
  localparam int DN_D = 1 + L3;

  // dot product slots: d1 = ab.ap, d2 = ac.ap, d3 = ab.bp, d4 = ac.bp, d5 = ab.cp, d6 = ac.cp
  localparam int D1 = 0;
  localparam int D2 = 1;
  localparam int D3 = 2;
  localparam int D4 = 3;
  localparam int D5 = 4;
  localparam int D6 = 5;
  localparam int VA = 0;
  localparam int VB = 1;
  localparam int VC = 2;
  // cross term operands: vc = P0 - P1, vb = P2 - P3, va = P4 - P5
  localparam int MA [6] = '{D1, D3, D5, D1, D3, D5};
  localparam int MB [6] = '{D4, D2, D2, D6, D6, D4};

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [DOT_W-1:0]  dot_t;
  typedef logic signed [EDG_W-1:0]  edg_t;
  typedef logic signed [VOL_W-1:0]  vol_t;
  typedef logic signed [DEN_W-1:0]  den_t;
  typedef logic signed [NUM_W-1:0]  num_t;

  logic [NST-1:0] vld_q;
  logic           en;

  assign en          = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // input register: p, a, b, c
  cpt_pkg::coord_t pt_q [4][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pt_q[0][0] <= in_data_i.point_x;
      pt_q[0][1] <= in_data_i.point_y;
      pt_q[0][2] <= in_data_i.point_z;
      pt_q[1][0] <= in_data_i.vert_a_x;
      pt_q[1][1] <= in_data_i.vert_a_y;
      pt_q[1][2] <= in_data_i.vert_a_z;
      pt_q[2][0] <= in_data_i.vert_b_x;
      pt_q[2][1] <= in_data_i.vert_b_y;
      pt_q[2][2] <= in_data_i.vert_b_z;
      pt_q[3][0] <= in_data_i.vert_c_x;
      pt_q[3][1] <= in_data_i.vert_c_y;
      pt_q[3][2] <= in_data_i.vert_c_z;
    end
  end

  // difference vectors: ev = ab, ac; pv = ap, bp, cp
  diff_t ev_q [2][3];
  diff_t pv_q [3][3];
  diff_t bc_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ev_q[0][i] <= DIFF_W'(pt_q[2][i]) - DIFF_W'(pt_q[1][i]);
        ev_q[1][i] <= DIFF_W'(pt_q[3][i]) - DIFF_W'(pt_q[1][i]);
        pv_q[0][i] <= DIFF_W'(pt_q[0][i]) - DIFF_W'(pt_q[1][i]);
        pv_q[1][i] <= DIFF_W'(pt_q[0][i]) - DIFF_W'(pt_q[2][i]);
        pv_q[2][i] <= DIFF_W'(pt_q[0][i]) - DIFF_W'(pt_q[3][i]);
        bc_q[i]    <= DIFF_W'(pt_q[3][i]) - DIFF_W'(pt_q[2][i]);
      end
    end
  end

  // vertices and edges wait for the region decision
  cpt_pkg::coord_t vt_dq [VT_D][3][3];
  diff_t           ed_dq [ED_D][3][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int v = 0; v < 3; v++) begin
          vt_dq[0][v][i] <= pt_q[v+1][i];
        end
        ed_dq[0][0][i] <= ev_q[0][i];
        ed_dq[0][1][i] <= ev_q[1][i];
        ed_dq[0][2][i] <= bc_q[i];
      end
      for (int k = 1; k < VT_D; k++) begin
        vt_dq[k] <= vt_dq[k-1];
      end
      for (int k = 1; k < ED_D; k++) begin
        ed_dq[k] <= ed_dq[k-1];
      end
    end
  end

  // dot product terms
  logic signed [2*DIFF_W-1:0] pr1 [6][3];

  for (genvar j = 0; j < 6; j++) begin : g_dot
    localparam int EI = j % 2;
    localparam int PI = j / 2;
    for (genvar i = 0; i < 3; i++) begin : g_ax
      cpt_mul #(
        .AW (DIFF_W),
        .BW (DIFF_W)
      ) u_mul (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (ev_q[EI][i]),
        .b_i   (pv_q[PI][i]),
        .p_o   (pr1[j][i])
      );
    end
  end

  dot_t dot_q [6];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        dot_q[j] <= DOT_W'(pr1[j][0]) + DOT_W'(pr1[j][1]) + DOT_W'(pr1[j][2]);
      end
    end
  end

  // cross products of dots
  logic signed [2*DOT_W-1:0] pr2 [6];

  for (genvar m = 0; m < 6; m++) begin : g_vol
    cpt_mul #(
      .AW (DOT_W),
      .BW (DOT_W)
    ) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (dot_q[MA[m]]),
      .b_i   (dot_q[MB[m]]),
      .p_o   (pr2[m])
    );
  end

  dot_t dt_dq [DT_D][6];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dt_dq[0] <= dot_q;
      for (int k = 1; k < DT_D; k++) begin
        dt_dq[k] <= dt_dq[k-1];
      end
    end
  end

  vol_t vol_q [3];
  dot_t dv_q  [6];
  edg_t e1_q, e2_q, dab_q, dac_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      vol_q[VC] <= VOL_W'(pr2[0]) - VOL_W'(pr2[1]);
      vol_q[VB] <= VOL_W'(pr2[2]) - VOL_W'(pr2[3]);
      vol_q[VA] <= VOL_W'(pr2[4]) - VOL_W'(pr2[5]);
      dv_q      <= dt_dq[DT_D-1];
      e1_q      <= EDG_W'(dt_dq[DT_D-1][D4]) - EDG_W'(dt_dq[DT_D-1][D3]);
      e2_q      <= EDG_W'(dt_dq[DT_D-1][D5]) - EDG_W'(dt_dq[DT_D-1][D6]);
      dab_q     <= EDG_W'(dt_dq[DT_D-1][D1]) - EDG_W'(dt_dq[DT_D-1][D3]);
      dac_q     <= EDG_W'(dt_dq[DT_D-1][D2]) - EDG_W'(dt_dq[DT_D-1][D6]);
    end
  end

  // region decision: vertices come out as base + 0 / 1
  logic            neg_d [6];
  logic            zer_d [6];
  logic            neg_v [3];
  logic            zer_v [3];
  logic            in_va, in_vb, in_vc, on_ab, on_ac, on_bc;
  den_t            den_int, den_bc;
  cpt_pkg::coord_t bs_c [3];
  diff_t           f0_c [3];
  diff_t           f1_c [3];
  vol_t            s0_c, s1_c;
  den_t            den_c;

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      neg_d[j] = dv_q[j][DOT_W-1];
      zer_d[j] = (dv_q[j] == '0);
    end
    for (int v = 0; v < 3; v++) begin
      neg_v[v] = vol_q[v][VOL_W-1];
      zer_v[v] = (vol_q[v] == '0);
    end
    den_int = DEN_W'(vol_q[VA]) + DEN_W'(vol_q[VB]) + DEN_W'(vol_q[VC]);
    den_bc  = DEN_W'(e1_q) + DEN_W'(e2_q);

    in_va = (neg_d[D1] || zer_d[D1]) && (neg_d[D2] || zer_d[D2]);
    in_vb = !neg_d[D3] && (e1_q[EDG_W-1] || (e1_q == '0));
    on_ab = (neg_v[VC] || zer_v[VC]) && !neg_d[D1] && (neg_d[D3] || zer_d[D3]);
    in_vc = !neg_d[D6] && (e2_q[EDG_W-1] || (e2_q == '0));
    on_ac = (neg_v[VB] || zer_v[VB]) && !neg_d[D2] && (neg_d[D6] || zer_d[D6]);
    on_bc = (neg_v[VA] || zer_v[VA]) && !e1_q[EDG_W-1] && !e2_q[EDG_W-1];

    for (int i = 0; i < 3; i++) begin
      bs_c[i] = vt_dq[VT_D-1][0][i];
      f0_c[i] = ed_dq[ED_D-1][0][i];
      f1_c[i] = ed_dq[ED_D-1][1][i];
    end
    s0_c  = '0;
    s1_c  = '0;
    den_c = DEN_W'(1);

    priority if (in_va) begin
      s0_c = '0;
    end else if (in_vb) begin
      for (int i = 0; i < 3; i++) bs_c[i] = vt_dq[VT_D-1][1][i];
    end else if (on_ab) begin
      if (dab_q != '0) begin
        s0_c  = VOL_W'(dv_q[D1]);
        den_c = DEN_W'(dab_q);
      end
    end else if (in_vc) begin
      for (int i = 0; i < 3; i++) bs_c[i] = vt_dq[VT_D-1][2][i];
    end else if (on_ac) begin
      for (int i = 0; i < 3; i++) f0_c[i] = ed_dq[ED_D-1][1][i];
      if (dac_q != '0) begin
        s0_c  = VOL_W'(dv_q[D2]);
        den_c = DEN_W'(dac_q);
      end
    end else if (on_bc) begin
      for (int i = 0; i < 3; i++) begin
        bs_c[i] = vt_dq[VT_D-1][1][i];
        f0_c[i] = ed_dq[ED_D-1][2][i];
      end
      if (den_bc != '0) begin
        s0_c  = VOL_W'(e1_q);
        den_c = den_bc;
      end
    end else begin
      // interior: ab*vb + ac*vc over va+vb+vc
      if (den_int != '0) begin
        s0_c  = vol_q[VB];
        s1_c  = vol_q[VC];
        den_c = den_int;
      end
    end
  end

  cpt_pkg::coord_t bs_q [3];
  diff_t           f0_q [3];
  diff_t           f1_q [3];
  vol_t            s0_q, s1_q;
  den_t            den_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      bs_q  <= bs_c;
      f0_q  <= f0_c;
      f1_q  <= f1_c;
      s0_q  <= s0_c;
      s1_q  <= s1_c;
      den_q <= den_c;
    end
  end

  // numerator products
  logic signed [DIFF_W+VOL_W-1:0] m0 [3];
  logic signed [DIFF_W+VOL_W-1:0] m1 [3];

  for (genvar i = 0; i < 3; i++) begin : g_num
    cpt_mul #(
      .AW (DIFF_W),
      .BW (VOL_W)
    ) u_mul0 (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (f0_q[i]),
      .b_i   (s0_q),
      .p_o   (m0[i])
    );
    cpt_mul #(
      .AW (DIFF_W),
      .BW (VOL_W)
    ) u_mul1 (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (f1_q[i]),
      .b_i   (s1_q),
      .p_o   (m1[i])
    );
  end

  cpt_pkg::coord_t bs_dq [BS_D][3];
  den_t            dn_dq [DN_D];

  always_ff @(posedge clk_i) begin
    if (en) begin
      bs_dq[0] <= bs_q;
      for (int k = 1; k < BS_D; k++) begin
        bs_dq[k] <= bs_dq[k-1];
      end
      dn_dq[0] <= den_q;
      for (int k = 1; k < DN_D; k++) begin
        dn_dq[k] <= dn_dq[k-1];
      end
    end
  end

  num_t num_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= NUM_W'(m0[i]) + NUM_W'(m1[i]);
      end
    end
  end

  // restoring divider on magnitudes, one quotient bit per stage; slot 0 holds the operands
  logic [REM_W-1:0] rm_q [QW+1][3];
  logic [QW-1:0]    ql_q [QW+1][3];
  logic             ng_q [QW+1][3];
  logic [DEN_W-1:0] dd_q [QW+1];
  logic [NUM_W-1:0] na_c [3];
  logic [DEN_W-1:0] da_c;
  logic [REM_W-1:0] sh_c [QW][3];
  logic [REM_W-1:0] rm_d [QW][3];
  logic [QW-1:0]    ql_d [QW][3];

  always_comb begin
    da_c = dn_dq[DN_D-1][DEN_W-1] ? DEN_W'(-dn_dq[DN_D-1]) : DEN_W'(dn_dq[DN_D-1]);
    for (int i = 0; i < 3; i++) begin
      na_c[i] = num_q[i][NUM_W-1] ? NUM_W'(-num_q[i]) : NUM_W'(num_q[i]);
    end
    for (int k = 0; k < QW; k++) begin
      for (int i = 0; i < 3; i++) begin
        sh_c[k][i] = {rm_q[k][i][REM_W-2:0], ql_q[k][i][QW-1]};
        if (sh_c[k][i] >= REM_W'(dd_q[k])) begin
          rm_d[k][i] = sh_c[k][i] - REM_W'(dd_q[k]);
          ql_d[k][i] = {ql_q[k][i][QW-2:0], 1'b1};
        end else begin
          rm_d[k][i] = sh_c[k][i];
          ql_d[k][i] = {ql_q[k][i][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dd_q[0] <= da_c;
      for (int i = 0; i < 3; i++) begin
        rm_q[0][i] <= REM_W'(na_c[i][NUM_W-1:QW]);
        ql_q[0][i] <= na_c[i][QW-1:0];
        ng_q[0][i] <= num_q[i][NUM_W-1] ^ dn_dq[DN_D-1][DEN_W-1];
      end
      for (int k = 0; k < QW; k++) begin
        dd_q[k+1] <= dd_q[k];
        for (int i = 0; i < 3; i++) begin
          rm_q[k+1][i] <= rm_d[k][i];
          ql_q[k+1][i] <= ql_d[k][i];
          ng_q[k+1][i] <= ng_q[k][i];
        end
      end
    end
  end

  // round half away from zero, then restore the sign
  logic [QW:0]          qm_c [3];
  logic signed [QW+1:0] qs_c [3];
  logic signed [QW+1:0] qs_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qm_c[i] = (QW+1)'(ql_q[QW][i]) +
                (QW+1)'({rm_q[QW][i], 1'b0} >= (REM_W+1)'(dd_q[QW]));
      qs_c[i] = ng_q[QW][i] ? -$signed({1'b0, qm_c[i]}) : $signed({1'b0, qm_c[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qs_q <= qs_c;
    end
  end

  // add the start vertex and clamp to the coordinate range
  logic signed [SUM_W-1:0] sum_c [3];
  cpt_pkg::coord_t         sat_c [3];
  cpt_pkg::coord_t         out_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_c[i] = SUM_W'(bs_dq[BS_D-1][i]) + SUM_W'(qs_q[i]);
      if (sum_c[i][SUM_W-1:COORD_W-1] == '0 || sum_c[i][SUM_W-1:COORD_W-1] == '1) begin
        sat_c[i] = sum_c[i][COORD_W-1:0];
      end else if (sum_c[i][SUM_W-1]) begin
        sat_c[i] = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        sat_c[i] = {1'b0, {(COORD_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= sat_c;
    end
  end

  assign out_data_o.near_x = out_q[0];
  assign out_data_o.near_y = out_q[1];
  assign out_data_o.near_z = out_q[2];

endmodule

// File: design/cpt_chk.sv
// port checker for the closest point on triangle block, bound to the top level
`timescale 1ns / 1ps

module cpt_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input cpt_pkg::cpt_out_t out_data_i
);

  // a held result keeps its transaction on the port
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output transaction dropped while stalled");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("output payload changed while stalled");

  // the input side stalls only behind an unaccepted result
  a_in_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output backpressure");

  // nothing in flight right after reset
  a_rst_empty : assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("output valid right after reset");

endmodule

bind closest_point_on_triangle cpt_chk u_cpt_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
